FILE: rtl/sfq_pkg.sv
// ----------------------------------------------------------------------------
// Shortest-first sorted queue package
// Sizes, status codes, control/status bundles and slot arithmetic that are
// shared by the controller, the datapath and the top level.
// ----------------------------------------------------------------------------
package sfq_pkg;

    localparam int DEPTH    = 128;
    localparam int PTR_W    = $clog2(DEPTH);
    localparam int CNT_W    = $clog2(DEPTH + 1);
    localparam int KEY_W    = 12;
    localparam int HANDLE_W = 16;
    localparam int STATUS_W = 2;
    localparam int OCC_W    = 8;

    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_REMOVE = 1'b1;

    localparam logic [STATUS_W-1:0] ST_INSERTED = 2'd0;
    localparam logic [STATUS_W-1:0] ST_REMOVED  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL     = 2'd2;
    localparam logic [STATUS_W-1:0] ST_EMPTY    = 2'd3;

    typedef struct packed {
        logic                load;
        logic                rd_prev;
        logic                rd_head;
        logic                wr_new;
        logic                wr_shift;
        logic                pop;
        logic                res_en;
        logic [STATUS_W-1:0] res_status;
    } t_cmd;

    typedef struct packed {
        logic is_insert;
        logic full;
        logic empty;
        logic pos_zero;
        logic key_le;
    } t_stat;

    // Physical slot of a position counted from the head, wrapping once.
    function automatic logic [PTR_W-1:0] slot_of(input logic [PTR_W-1:0] head,
                                                 input logic [CNT_W-1:0] pos);
        logic [CNT_W:0] sum;
        sum = (CNT_W+1)'(head) + (CNT_W+1)'(pos);
        if (sum >= (CNT_W+1)'(DEPTH)) begin
            sum = sum - (CNT_W+1)'(DEPTH);
        end
        return sum[PTR_W-1:0];
    endfunction

endpackage

FILE: rtl/sfq_ctrl.sv
// ----------------------------------------------------------------------------
// Shortest-first sorted queue controller
// Sequences one request at a time: dispatch, the read/compare walk toward the
// insertion point, the head pop, and the single result.
// ----------------------------------------------------------------------------
module sfq_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          start,
    input  sfq_pkg::t_stat i_stat,
    output logic          busy,
    output sfq_pkg::t_cmd o_cmd
);

    localparam logic [1:0] S_IDLE     = 2'd0;
    localparam logic [1:0] S_DISPATCH = 2'd1;
    localparam logic [1:0] S_CMP      = 2'd2;
    localparam logic [1:0] S_POP      = 2'd3;

    logic [1:0] r_state;
    logic [1:0] n_state;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (start) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_DISPATCH;
                end
            end
            S_DISPATCH: begin
                if (i_stat.is_insert) begin
                    if (i_stat.full) begin
                        o_cmd.res_en     = 1'b1;
                        o_cmd.res_status = sfq_pkg::ST_FULL;
                        n_state          = S_IDLE;
                    end else if (i_stat.pos_zero) begin
                        o_cmd.wr_new     = 1'b1;
                        o_cmd.res_en     = 1'b1;
                        o_cmd.res_status = sfq_pkg::ST_INSERTED;
                        n_state          = S_IDLE;
                    end else begin
                        o_cmd.rd_prev = 1'b1;
                        n_state       = S_CMP;
                    end
                end else begin
                    if (i_stat.empty) begin
                        o_cmd.res_en     = 1'b1;
                        o_cmd.res_status = sfq_pkg::ST_EMPTY;
                        n_state          = S_IDLE;
                    end else begin
                        o_cmd.rd_head = 1'b1;
                        n_state       = S_POP;
                    end
                end
            end
            S_CMP: begin
                if (i_stat.key_le) begin
                    o_cmd.wr_new     = 1'b1;
                    o_cmd.res_en     = 1'b1;
                    o_cmd.res_status = sfq_pkg::ST_INSERTED;
                    n_state          = S_IDLE;
                end else begin
                    o_cmd.wr_shift = 1'b1;
                    n_state        = S_DISPATCH;
                end
            end
            S_POP: begin
                o_cmd.pop        = 1'b1;
                o_cmd.res_en     = 1'b1;
                o_cmd.res_status = sfq_pkg::ST_REMOVED;
                n_state          = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign busy = (r_state != S_IDLE);

endmodule

FILE: rtl/sfq_datapath.sv
// ----------------------------------------------------------------------------
// Shortest-first sorted queue datapath
// Circular key and handle memories, head pointer, entry count, walk position,
// request latch and the result register.
// ----------------------------------------------------------------------------
module sfq_datapath (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  sfq_pkg::t_cmd                    i_cmd,
    input  logic                             i_opcode,
    input  logic [sfq_pkg::KEY_W-1:0]        i_key_length,
    input  logic [sfq_pkg::HANDLE_W-1:0]     i_payload_handle,
    output sfq_pkg::t_stat                   o_stat,
    output logic                             o_done,
    output logic [sfq_pkg::STATUS_W-1:0]     o_status,
    output logic [sfq_pkg::KEY_W-1:0]        o_out_key,
    output logic [sfq_pkg::HANDLE_W-1:0]     o_out_handle,
    output logic [sfq_pkg::OCC_W-1:0]        o_occupancy
);

    logic [sfq_pkg::KEY_W-1:0]    key_mem    [sfq_pkg::DEPTH];
    logic [sfq_pkg::HANDLE_W-1:0] handle_mem [sfq_pkg::DEPTH];

    logic [sfq_pkg::PTR_W-1:0]    r_head;
    logic [sfq_pkg::PTR_W-1:0]    n_head;
    logic [sfq_pkg::CNT_W-1:0]    r_count;
    logic [sfq_pkg::CNT_W-1:0]    n_count;
    logic [sfq_pkg::CNT_W-1:0]    r_pos;
    logic                         r_op;
    logic [sfq_pkg::KEY_W-1:0]    r_key;
    logic [sfq_pkg::HANDLE_W-1:0] r_handle;
    logic [sfq_pkg::KEY_W-1:0]    r_rd_key;
    logic [sfq_pkg::HANDLE_W-1:0] r_rd_handle;
    logic                         r_done;
    logic [sfq_pkg::STATUS_W-1:0] r_status;
    logic [sfq_pkg::KEY_W-1:0]    r_out_key;
    logic [sfq_pkg::HANDLE_W-1:0] r_out_handle;
    logic [sfq_pkg::OCC_W-1:0]    r_occ;

    logic [sfq_pkg::PTR_W-1:0]    wr_addr;
    logic [sfq_pkg::PTR_W-1:0]    rd_addr;
    logic [sfq_pkg::KEY_W-1:0]    wr_key;
    logic [sfq_pkg::HANDLE_W-1:0] wr_handle;

    assign wr_addr   = sfq_pkg::slot_of(r_head, r_pos);
    assign rd_addr   = i_cmd.rd_head ? r_head
                                     : sfq_pkg::slot_of(r_head, r_pos - sfq_pkg::CNT_W'(1));
    assign wr_key    = i_cmd.wr_new ? r_key    : r_rd_key;
    assign wr_handle = i_cmd.wr_new ? r_handle : r_rd_handle;

    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_new || i_cmd.wr_shift) begin
            key_mem[wr_addr]    <= wr_key;
            handle_mem[wr_addr] <= wr_handle;
        end
        if (i_cmd.rd_prev || i_cmd.rd_head) begin
            r_rd_key    <= key_mem[rd_addr];
            r_rd_handle <= handle_mem[rd_addr];
        end
    end

    always_comb begin
        n_count = r_count;
        n_head  = r_head;
        if (i_cmd.wr_new) begin
            n_count = r_count + sfq_pkg::CNT_W'(1);
        end else if (i_cmd.pop) begin
            n_count = r_count - sfq_pkg::CNT_W'(1);
            if (r_head == sfq_pkg::PTR_W'(sfq_pkg::DEPTH - 1)) begin
                n_head = '0;
            end else begin
                n_head = r_head + sfq_pkg::PTR_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head  <= '0;
            r_count <= '0;
            r_done  <= 1'b0;
        end else begin
            r_head  <= n_head;
            r_count <= n_count;
            r_done  <= i_cmd.res_en;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op     <= i_opcode;
            r_key    <= i_key_length;
            r_handle <= i_payload_handle;
            r_pos    <= r_count;
        end else if (i_cmd.wr_shift) begin
            r_pos <= r_pos - sfq_pkg::CNT_W'(1);
        end
        if (i_cmd.res_en) begin
            r_status     <= i_cmd.res_status;
            r_out_key    <= i_cmd.pop ? r_rd_key    : '0;
            r_out_handle <= i_cmd.pop ? r_rd_handle : '0;
            r_occ        <= sfq_pkg::OCC_W'(n_count);
        end
    end

    assign o_stat.is_insert = (r_op == sfq_pkg::OP_INSERT);
    assign o_stat.full      = (r_count == sfq_pkg::CNT_W'(sfq_pkg::DEPTH));
    assign o_stat.empty     = (r_count == '0);
    assign o_stat.pos_zero  = (r_pos == '0);
    assign o_stat.key_le    = (r_rd_key <= r_key);

    assign o_done       = r_done;
    assign o_status     = r_status;
    assign o_out_key    = r_out_key;
    assign o_out_handle = r_out_handle;
    assign o_occupancy  = r_occ;

endmodule

FILE: rtl/shortest_first_sorted_queue_core.sv
// ----------------------------------------------------------------------------
// Shortest-first sorted queue core
// Keeps requests in ascending key order in a circular memory; equal keys keep
// arrival order. Insert walks from the tail shifting larger keys, remove pops
// the head.
//
//   channel   | handshake             | fields
//   ----------+-----------------------+-------------------------------------
//   request   | start, busy           | i_opcode, i_key_length,
//             |                       | i_payload_handle
//   result    | o_done (one cycle)    | o_status, o_out_key, o_out_handle,
//             |                       | o_occupancy
//
// A request is taken when start is high and busy is low. A rejection is
// decided in the dispatch state, a remove reads the head and then pops it, and
// an insert steps from the tail toward the head; each shift step is one memory
// read followed by one compare and write, and the walk ends at the head or at a
// smaller or equal key. Busy falls with the result strobe, so the next request
// can be taken at the edge that ends the strobe cycle. Reset empties the queue;
// the memories are not cleared. The receiver cannot stall a result.
// ----------------------------------------------------------------------------
module shortest_first_sorted_queue_core (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         start,
    output logic                         busy,
    input  logic                         i_opcode,
    input  logic [sfq_pkg::KEY_W-1:0]    i_key_length,
    input  logic [sfq_pkg::HANDLE_W-1:0] i_payload_handle,
    output logic                         o_done,
    output logic [sfq_pkg::STATUS_W-1:0] o_status,
    output logic [sfq_pkg::KEY_W-1:0]    o_out_key,
    output logic [sfq_pkg::HANDLE_W-1:0] o_out_handle,
    output logic [sfq_pkg::OCC_W-1:0]    o_occupancy
);

    sfq_pkg::t_cmd  cmd;
    sfq_pkg::t_stat stat;

    sfq_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .i_stat  (stat),
        .busy    (busy),
        .o_cmd   (cmd)
    );

    sfq_datapath u_datapath (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (cmd),
        .i_opcode         (i_opcode),
        .i_key_length     (i_key_length),
        .i_payload_handle (i_payload_handle),
        .o_stat           (stat),
        .o_done           (o_done),
        .o_status         (o_status),
        .o_out_key        (o_out_key),
        .o_out_handle     (o_out_handle),
        .o_occupancy      (o_occupancy)
    );

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("accepted request did not raise busy");

    a_reject_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_status != sfq_pkg::ST_REMOVED) |-> (o_out_key == '0 && o_out_handle == '0))
        else $error("non-remove result carries entry data");

    a_empty_occ: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_status == sfq_pkg::ST_EMPTY) |-> (o_occupancy == '0))
        else $error("empty rejection with nonzero occupancy");

    a_full_occ: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_status == sfq_pkg::ST_FULL)
            |-> (o_occupancy == sfq_pkg::OCC_W'(sfq_pkg::DEPTH)))
        else $error("full rejection with wrong occupancy");

endmodule

FILE: sim/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Testbench for the shortest-first sorted queue core
// Sends insert and remove requests through the start/busy handshake and keeps
// a sorted copy of the queue contents. Each request predicts one result, and
// every o_done strobe is checked field by field against the oldest prediction.
// The random part fills the queue past full and drains it past empty in turn.
// ----------------------------------------------------------------------------

typedef struct packed {
    logic [sfq_pkg::KEY_W-1:0]    key;
    logic [sfq_pkg::HANDLE_W-1:0] handle;
} t_queued_req;

typedef struct packed {
    logic [sfq_pkg::STATUS_W-1:0] status;
    logic [sfq_pkg::KEY_W-1:0]    key;
    logic [sfq_pkg::HANDLE_W-1:0] handle;
    logic [sfq_pkg::OCC_W-1:0]    occupancy;
} t_queue_outcome;

class shortest_first_tracker;
    t_queued_req    held_requests[$];
    t_queue_outcome awaited_outcomes[$];
    int             errors;

    function new();
        errors = 0;
    endfunction

    function void note_request(logic op, logic [sfq_pkg::KEY_W-1:0] key,
                               logic [sfq_pkg::HANDLE_W-1:0] handle);
        t_queue_outcome outcome;
        t_queued_req    entry;
        int             pos;
        outcome = '0;
        if (op == sfq_pkg::OP_INSERT) begin
            if (held_requests.size() >= sfq_pkg::DEPTH) begin
                outcome.status = sfq_pkg::ST_FULL;
            end else begin
                pos = held_requests.size();
                while (pos > 0 && held_requests[pos-1].key > key) begin
                    pos--;
                end
                entry.key    = key;
                entry.handle = handle;
                held_requests.insert(pos, entry);
                outcome.status = sfq_pkg::ST_INSERTED;
            end
        end else if (held_requests.size() == 0) begin
            outcome.status = sfq_pkg::ST_EMPTY;
        end else begin
            entry          = held_requests.pop_front();
            outcome.status = sfq_pkg::ST_REMOVED;
            outcome.key    = entry.key;
            outcome.handle = entry.handle;
        end
        outcome.occupancy = sfq_pkg::OCC_W'(held_requests.size());
        awaited_outcomes.push_back(outcome);
    endfunction

    function void compare_field(string name, int unsigned want, int unsigned got);
        if (want != got) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            errors++;
        end
    endfunction

    function void check_result(logic [sfq_pkg::STATUS_W-1:0] status,
                               logic [sfq_pkg::KEY_W-1:0] key,
                               logic [sfq_pkg::HANDLE_W-1:0] handle,
                               logic [sfq_pkg::OCC_W-1:0] occupancy);
        t_queue_outcome want;
        if (awaited_outcomes.size() == 0) begin
            $display("%0t: unexpected result, expected none, actual status %0d", $time,
                     status);
            errors++;
            return;
        end
        want = awaited_outcomes.pop_front();
        compare_field("status", want.status, status);
        compare_field("out_key", want.key, key);
        compare_field("out_handle", want.handle, handle);
        compare_field("occupancy", want.occupancy, occupancy);
    endfunction
endclass

module tb_top;

    localparam int RANDOM_REQUESTS = 450;
    localparam int QUIET_LIMIT     = 2000;
    localparam int SETTLE_CYCLES   = 16;

    logic                         i_clk = 1'b0;
    logic                         i_rst_n = 1'b0;
    logic                         start = 1'b0;
    logic                         busy;
    logic                         i_opcode = sfq_pkg::OP_INSERT;
    logic [sfq_pkg::KEY_W-1:0]    i_key_length = '0;
    logic [sfq_pkg::HANDLE_W-1:0] i_payload_handle = '0;
    logic                         o_done;
    logic [sfq_pkg::STATUS_W-1:0] o_status;
    logic [sfq_pkg::KEY_W-1:0]    o_out_key;
    logic [sfq_pkg::HANDLE_W-1:0] o_out_handle;
    logic [sfq_pkg::OCC_W-1:0]    o_occupancy;

    shortest_first_tracker tracker = new();
    bit                    steady = 1'b0;
    int                    quiet_cycles = 0;
    int                    fill_level = 0;

    shortest_first_sorted_queue_core dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .start            (start),
        .busy             (busy),
        .i_opcode         (i_opcode),
        .i_key_length     (i_key_length),
        .i_payload_handle (i_payload_handle),
        .o_done           (o_done),
        .o_status         (o_status),
        .o_out_key        (o_out_key),
        .o_out_handle     (o_out_handle),
        .o_occupancy      (o_occupancy)
    );

    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (start && !busy) begin
                tracker.note_request(i_opcode, i_key_length, i_payload_handle);
            end
            if (o_done) begin
                tracker.check_result(o_status, o_out_key, o_out_handle, o_occupancy);
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || o_done) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("shortest_first_sorted_queue_core verification failed");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic send_request(input logic op, input logic [sfq_pkg::KEY_W-1:0] key,
                                input logic [sfq_pkg::HANDLE_W-1:0] handle);
        i_opcode         <= op;
        i_key_length     <= key;
        i_payload_handle <= handle;
        do begin
            start <= steady || ($urandom_range(0, 99) >= 27);
            @(posedge i_clk);
        end while (!(start && !busy));
        if (op == sfq_pkg::OP_INSERT) begin
            if (fill_level < sfq_pkg::DEPTH) fill_level++;
        end else if (fill_level > 0) begin
            fill_level--;
        end
    endtask

    task automatic send_random_request(input bit filling);
        logic                         op;
        logic [sfq_pkg::KEY_W-1:0]    key;
        bit                           favored;
        favored = ($urandom_range(0, 99) < 85);
        op = (filling == favored) ? sfq_pkg::OP_INSERT : sfq_pkg::OP_REMOVE;
        case ($urandom_range(0, 3))
            0: key = sfq_pkg::KEY_W'($urandom_range(0, 7));
            1: key = $urandom_range(0, 1) ? '1 : '0;
            default: key = sfq_pkg::KEY_W'($urandom);
        endcase
        send_request(op, key, sfq_pkg::HANDLE_W'($urandom));
    endtask

    initial begin
        bit filling;
        int at_limit;
        filling  = 1'b1;
        at_limit = 0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part: empty rejection, both key extremes, shifting inserts,
        // equal keys leaving in arrival order, then draining past empty.
        send_request(sfq_pkg::OP_REMOVE, '1, '1);
        send_request(sfq_pkg::OP_INSERT, 12'd100, 16'h1111);
        send_request(sfq_pkg::OP_INSERT, '0, '0);
        send_request(sfq_pkg::OP_INSERT, '1, '1);
        send_request(sfq_pkg::OP_INSERT, 12'd100, 16'h2222);
        send_request(sfq_pkg::OP_INSERT, 12'd100, 16'h3333);
        send_request(sfq_pkg::OP_INSERT, 12'd50, 16'hAAAA);
        send_request(sfq_pkg::OP_INSERT, 12'd4094, 16'h5555);
        repeat (8) send_request(sfq_pkg::OP_REMOVE, 12'h5A5, 16'hA5A5);
        send_request(sfq_pkg::OP_INSERT, 12'd7, 16'h0F0F);
        send_request(sfq_pkg::OP_INSERT, 12'd7, 16'hF0F0);
        send_request(sfq_pkg::OP_REMOVE, '0, '0);

        // Random part: alternately fill past full and drain past empty.
        for (int n = 0; n < RANDOM_REQUESTS; n++) begin
            steady = (n >= 120 && n < 200);
            send_random_request(filling);
            if ((filling && fill_level == sfq_pkg::DEPTH)
                    || (!filling && fill_level == 0)) begin
                at_limit++;
            end
            if (at_limit >= 4) begin
                filling  = !filling;
                at_limit = 0;
            end
        end
        start <= 1'b0;

        while (tracker.awaited_outcomes.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (tracker.errors == 0) begin
            $display("shortest_first_sorted_queue_core verification clean");
        end else begin
            $display("shortest_first_sorted_queue_core verification failed");
        end
        $finish;
    end

endmodule
